// ===== src/lzss_pkg.sv =====
`timescale 1ns / 1ps

package lzss_pkg;

    // Defaults for the top-level parameters
    localparam int unsigned HISTORY_DEPTH_DEF = 4096;
    localparam int unsigned QUEUE_DEPTH_DEF   = 4;

    // Stream format
    localparam int unsigned START_BACKOFF = 18;   // write position starts this far below the top
    localparam int unsigned MIN_MATCH     = 3;
    localparam int unsigned MAX_RUN       = 18;   // longest reference: 15 + MIN_MATCH
    localparam int unsigned FLAG_BITS     = 8;
    localparam int unsigned OFFSET_W      = 12;   // offset field of a reference
    localparam int unsigned RUN_W         = $clog2(MAX_RUN + 1);
    localparam int unsigned LEN_W         = 32;   // output_length and byte counter

    // One command from the front end to the copy engine
    typedef struct packed {
        logic                is_copy;  // 0: literal, 1: copy from the ring
        logic [OFFSET_W-1:0] src;      // ring offset of the first copied byte
        logic [7:0]          lit;      // literal byte
        logic [RUN_W-1:0]    count;    // bytes to emit, 1 to MAX_RUN
        logic                done;     // last byte of this command ends the stream
    } t_cmd;

endpackage

// ===== src/lzss_front.sv =====
`timescale 1ns / 1ps

module lzss_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [lzss_pkg::LEN_W-1:0] i_cfg_wr_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [7:0]               i_byte,
    output logic                     o_push,
    output lzss_pkg::t_cmd           o_cmd,
    input  logic                     i_full
);
    import lzss_pkg::*;

    logic [7:0]       r_flag_shift, n_flag_shift;
    logic [3:0]       r_flags_left, n_flags_left;
    logic             r_await, n_await;
    logic [7:0]       r_first, n_first;
    logic [LEN_W-1:0] r_sched, n_sched;
    logic [LEN_W-1:0] r_out_len;

    logic             accept;
    logic             stream_over;
    logic [LEN_W-1:0] rem;
    logic [RUN_W-1:0] run_len;
    logic [RUN_W-1:0] run_cut;

    assign o_ready     = !i_full;
    assign accept      = i_valid && !i_full;
    assign stream_over = (r_sched >= r_out_len);
    assign rem         = r_out_len - r_sched;
    assign run_len     = RUN_W'(i_byte[3:0]) + RUN_W'(MIN_MATCH);
    // clip the run where the stream ends
    assign run_cut     = (rem < LEN_W'(run_len)) ? rem[RUN_W-1:0] : run_len;

    always_comb begin
        n_flag_shift  = r_flag_shift;
        n_flags_left  = r_flags_left;
        n_await       = r_await;
        n_first       = r_first;
        n_sched       = r_sched;
        o_push        = 1'b0;
        o_cmd.is_copy = 1'b0;
        o_cmd.src     = {i_byte[7:4], r_first};
        o_cmd.lit     = i_byte;
        o_cmd.count   = RUN_W'(1);
        o_cmd.done    = (rem == LEN_W'(1));
        if (accept && !stream_over) begin
            if (r_flags_left == 4'd0) begin
                n_flag_shift = i_byte;
                n_flags_left = 4'(FLAG_BITS);
            end else if (r_flag_shift[0]) begin
                o_push       = 1'b1;
                n_sched      = r_sched + LEN_W'(1);
                n_flag_shift = r_flag_shift >> 1;
                n_flags_left = r_flags_left - 4'd1;
            end else if (!r_await) begin
                n_first = i_byte;
                n_await = 1'b1;
            end else begin
                o_push        = 1'b1;
                o_cmd.is_copy = 1'b1;
                o_cmd.count   = run_cut;
                o_cmd.done    = (rem <= LEN_W'(run_len));
                n_await       = 1'b0;
                n_sched       = r_sched + LEN_W'(run_cut);
                n_flag_shift  = r_flag_shift >> 1;
                n_flags_left  = r_flags_left - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag_shift <= '0;
            r_flags_left <= '0;
            r_await      <= 1'b0;
            r_first      <= '0;
            r_sched      <= '0;
            r_out_len    <= '0;
        end else begin
            r_flag_shift <= n_flag_shift;
            r_flags_left <= n_flags_left;
            r_await      <= n_await;
            r_first      <= n_first;
            r_sched      <= n_sched;
            if (i_cfg_wr_en) begin
                r_out_len <= i_cfg_wr_data;
            end
        end
    end

    a_flags_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags_left <= 4'(FLAG_BITS))
        else $error("flag counter out of range");

    a_cmd_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_cmd.count != '0) && (o_cmd.count <= RUN_W'(MAX_RUN)))
        else $error("command with bad byte count");

endmodule

// ===== src/lzss_cmd_fifo.sv =====
`timescale 1ns / 1ps

module lzss_cmd_fifo #(
    parameter int unsigned DEPTH = lzss_pkg::QUEUE_DEPTH_DEF   // 2 or more
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lzss_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output lzss_pkg::t_cmd o_cmd
);
    import lzss_pkg::*;

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cmd          r_slot [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CW'(DEPTH)) || i_pop)
        else $error("push into full command queue");

endmodule

// ===== src/lzss_back.sv =====
`timescale 1ns / 1ps

module lzss_back #(
    parameter int unsigned HISTORY_DEPTH = lzss_pkg::HISTORY_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  lzss_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_byte,
    output logic           o_last,
    output logic           o_done
);
    import lzss_pkg::*;

    localparam int unsigned AW = $clog2(HISTORY_DEPTH);
    localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [AW-1:0] START_POS = AW'(HISTORY_DEPTH - START_BACKOFF);

    logic [7:0]       r_mem [HISTORY_DEPTH];
    logic [7:0]       r_mem_q;

    // ring bookkeeping: entries are written in order from START_POS, so a
    // fill count tells which entries are still unwritten and so read as zero
    logic [AW-1:0]    r_wp;
    logic [FW-1:0]    r_fill;

    // command being expanded
    logic [AW-1:0]    r_src;
    logic [RUN_W-1:0] r_left;
    logic             r_is_copy;
    logic [7:0]       r_lit;
    logic             r_cmd_done;

    // fetched byte waiting to commit
    logic             r_rd_valid;
    logic             r_rd_lit;
    logic [7:0]       r_rd_lit_byte;
    logic             r_rd_zero;
    logic             r_rd_byp;
    logic [7:0]       r_byp_byte;
    logic             r_rd_last;
    logic             r_rd_done;

    // output register
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             r_out_done;

    logic [7:0]       rd_byte;
    logic             commit;
    logic             fetch;
    logic             mem_rd_en;
    logic [AW-1:0]    src_age;
    logic             src_written;
    logic             byp_hit;

    assign rd_byte     = r_rd_lit  ? r_rd_lit_byte :
                         r_rd_byp  ? r_byp_byte    :
                         r_rd_zero ? 8'd0          : r_mem_q;
    assign commit      = r_rd_valid && (!r_out_valid || i_ready);
    assign fetch       = (r_left != '0) && (!r_rd_valid || commit);
    assign o_cmd_pop   = (r_left == '0) && i_cmd_valid;
    assign mem_rd_en   = fetch && r_is_copy;
    assign src_age     = r_src - START_POS;
    assign src_written = (FW'(src_age) < r_fill);
    // the entry committed in this cycle is not yet visible through the read port
    assign byp_hit     = commit && r_is_copy && (r_src == r_wp);

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;
    assign o_done  = r_out_done;

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_mem[r_wp] <= rd_byte;
        end
        if (mem_rd_en) begin
            r_mem_q <= r_mem[r_src];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_src      <= AW'(i_cmd.src);
            r_is_copy  <= i_cmd.is_copy;
            r_lit      <= i_cmd.lit;
            r_cmd_done <= i_cmd.done;
        end else if (fetch) begin
            r_src <= r_src + AW'(1);
        end
        if (fetch) begin
            r_rd_lit      <= !r_is_copy;
            r_rd_lit_byte <= r_lit;
            r_rd_zero     <= !src_written;
            r_rd_byp      <= byp_hit;
            r_byp_byte    <= rd_byte;
            r_rd_last     <= (r_left == RUN_W'(1));
            r_rd_done     <= r_cmd_done && (r_left == RUN_W'(1));
        end
        if (commit) begin
            r_out_byte <= rd_byte;
            r_out_last <= r_rd_last;
            r_out_done <= r_rd_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= START_POS;
            r_fill      <= '0;
            r_left      <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_left <= i_cmd.count;
            end else if (fetch) begin
                r_left <= r_left - RUN_W'(1);
            end
            if (fetch) begin
                r_rd_valid <= 1'b1;
            end else if (commit) begin
                r_rd_valid <= 1'b0;
            end
            if (commit) begin
                r_wp <= r_wp + AW'(1);
                if (r_fill != FW'(HISTORY_DEPTH)) begin
                    r_fill <= r_fill + FW'(1);
                end
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(HISTORY_DEPTH))
        else $error("ring fill count overran");

    a_pending_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid && !commit |=> r_rd_valid && $stable(r_rd_last))
        else $error("fetched byte lost before commit");

    a_bypass_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid && r_rd_byp |-> !r_rd_lit)
        else $error("bypass flagged on a literal");

endmodule

// ===== src/lzss_ring_buffer_decompressor_top.sv =====
`timescale 1ns / 1ps

// LZSS decompressor with a 4 KiB history ring. Feed the compressed stream one
// byte per beat on the slave side; decompressed bytes leave one per beat on
// the master side, tlast marking the last byte produced by an input byte and
// tuser marking the byte that completes output_length. Write output_length
// through i_cfg_wr_en/i_cfg_wr_data while idle, before the stream starts;
// once that many bytes are out, further input is accepted and dropped. The
// ring reads as zeros until written, tracked by a fill count, so there is no
// clearing pass after reset. A front end parses flag and reference bytes and
// takes one input byte per cycle while its command queue (QUEUE_DEPTH entries)
// has room. The copy engine behind the queue loads a command when it has no
// bytes left to expand and then emits one byte per cycle through the ring
// while the master side accepts them. The ring has one read port and one
// write port, and that engine sets the sustained rate.
module lzss_ring_buffer_decompressor_top #(
    parameter int unsigned HISTORY_DEPTH = lzss_pkg::HISTORY_DEPTH_DEF,
    parameter int unsigned QUEUE_DEPTH   = lzss_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [lzss_pkg::LEN_W-1:0] i_cfg_wr_data,   // output_length
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [7:0]                 i_s_axis_tdata,  // [7:0] in_byte
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [7:0]                 o_m_axis_tdata,  // [7:0] out_byte
    output logic                       o_m_axis_tlast,  // run_end
    output logic                       o_m_axis_tuser   // [0] stream_done
);
    import lzss_pkg::*;

    logic push;
    logic full;
    logic q_valid;
    logic pop;
    t_cmd push_cmd;
    t_cmd q_cmd;

    // parse flag bytes, literals and reference pairs into commands
    lzss_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_byte        (i_s_axis_tdata),
        .o_push        (push),
        .o_cmd         (push_cmd),
        .i_full        (full)
    );

    // decouple parsing from byte emission
    lzss_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_cmd   (q_cmd)
    );

    // expand commands into bytes and write each one back into the ring
    lzss_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_byte      (o_m_axis_tdata),
        .o_last      (o_m_axis_tlast),
        .o_done      (o_m_axis_tuser)
    );

endmodule
